// ===== hdl/lzmv_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the marker/varint lz decoder
// no dependencies

package lzmv_pkg;

	localparam int WINDOW_SIZE = 4096;
	localparam int MAX_COPY    = 64;

	localparam int AW    = $clog2(WINDOW_SIZE);
	localparam int WC_W  = $clog2(WINDOW_SIZE) + 1;
	localparam int CNT_W = $clog2(MAX_COPY + 1);
	localparam int ACC_W = 32;

	localparam logic [7:0]       VAR_MASK   = 8'h7f;
	localparam int               COPY_BIAS  = 3;
	localparam logic [ACC_W-1:0] LEN_LIMIT  = ACC_W'(MAX_COPY - COPY_BIAS);
	localparam logic [ACC_W-1:0] SAT_LIMIT  = {ACC_W{1'b1}} >> 7;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_TRUNC = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_LONG  = 2'd3;

	typedef enum logic [2:0] {
		PH_HEAD      = 3'd0,
		PH_LIT1      = 3'd1,
		PH_BODY      = 3'd2,
		PH_OFF       = 3'd3,
		PH_LEN       = 3'd4,
		PH_ERR_TRUNC = 3'd5,
		PH_ERR_RANGE = 3'd6,
		PH_ERR_LONG  = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_COPY
	} seq_t;

	// result of one varint step
	typedef struct packed {
		logic [ACC_W-1:0] acc_next;
		logic             more;
		logic             is_zero;
		logic             over;
	} vres_t;

endpackage

// ===== hdl/lz_marker_varint_decoder_unit.sv =====
`timescale 1ns / 1ps
// marker-escaped lz77 decoder: top level with sequencer, history ram and output register
// depends on lzmv_pkg, lzmv_ram, lzmv_varint_unit
// flow: an input byte is captured in idle, decoded, and its result written to the output register;
//   a copy instead goes through a registered ram read and a copy step for each of its L+3 bytes
//   no new input byte is taken until the last one is through; a full output register stalls both
// reset: arst_n clears sequencer, phase, pointers and output valid; history is not cleared

module lz_marker_varint_decoder_unit
	import lzmv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_has_byte,
	output logic       out_last,
	output logic [1:0] status
);

	// control state
	seq_t             state_q, state_d;
	phase_t           phase_q, phase_d;
	logic [AW-1:0]    wp_q, wp_d;
	logic [WC_W-1:0]  wc_q, wc_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;

	// payload state
	logic [7:0]       marker_q, marker_d;
	logic [ACC_W-1:0] offset_q, offset_d;
	logic [ACC_W-1:0] length_q, length_d;
	logic [7:0]       byte_q;
	logic             last_q;
	logic [7:0]       out_byte_q;
	logic             out_has_q;
	logic             out_last_q;
	logic [1:0]       status_q;

	// datapath controls
	logic             slot_free;
	logic             load;
	logic             emit;
	logic             start_copy;
	logic             end_stream;
	logic             rd_en;
	logic [7:0]       wr_data;
	logic [7:0]       rd_data;
	logic [AW-1:0]    rd_addr;
	logic [7:0]       res_byte;
	logic             res_has;
	logic             res_last;
	logic [1:0]       res_status;

	// shared varint unit
	logic [ACC_W-1:0] v_acc;
	logic [ACC_W-1:0] v_limit;
	vres_t            vres;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);

	// offset and length both run through the one unit
	assign v_acc   = (phase_q == PH_OFF) ? offset_q : length_q;
	assign v_limit = (phase_q == PH_OFF) ? ACC_W'(wc_q) : LEN_LIMIT;

	lzmv_varint_unit u_varint (
		.acc     (v_acc),
		.byte_in (byte_q),
		.limit   (v_limit),
		.res     (vres)
	);

	// copy source: distance back from the write pointer, modulo the window
	assign rd_addr = wp_q - offset_q[AW-1:0];

	lzmv_ram #(
		.WIDTH (8),
		.DEPTH (WINDOW_SIZE)
	) u_history (
		.clk     (clk),
		.wr_en   (emit),
		.wr_addr (wp_q),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (slot_free) begin
					state_d = start_copy ? S_READ : S_IDLE;
				end
			end
			S_READ: begin
				state_d = S_COPY;
			end
			S_COPY: begin
				if (slot_free) begin
					state_d = (cnt_q == CNT_W'(1)) ? S_IDLE : S_READ;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// sequencer outputs and state updates
	always_comb begin
		phase_d    = phase_q;
		marker_d   = marker_q;
		offset_d   = offset_q;
		length_d   = length_q;
		cnt_d      = cnt_q;
		wp_d       = wp_q;
		wc_d       = wc_q;
		load       = 1'b0;
		emit       = 1'b0;
		start_copy = 1'b0;
		end_stream = 1'b0;
		rd_en      = 1'b0;
		wr_data    = byte_q;
		res_last   = 1'b1;

		unique case (state_q)
			S_IDLE: begin
			end
			S_DECODE: begin
				if (slot_free) begin
					unique case (phase_q)
						PH_HEAD: begin
							marker_d = byte_q;
							phase_d  = PH_LIT1;
						end
						PH_LIT1: begin
							emit    = 1'b1;
							phase_d = PH_BODY;
						end
						PH_BODY: begin
							if (byte_q != marker_q) begin
								emit = 1'b1;
							end else begin
								offset_d = '0;
								phase_d  = PH_OFF;
							end
						end
						PH_OFF: begin
							offset_d = vres.acc_next;
							if (!vres.more) begin
								if (vres.is_zero) begin
									// escaped marker
									emit    = 1'b1;
									wr_data = marker_q;
									phase_d = PH_BODY;
								end else if (vres.over) begin
									phase_d = PH_ERR_RANGE;
								end else begin
									length_d = '0;
									phase_d  = PH_LEN;
								end
							end
						end
						PH_LEN: begin
							length_d = vres.acc_next;
							if (!vres.more) begin
								if (vres.over) begin
									phase_d = PH_ERR_LONG;
								end else begin
									start_copy = 1'b1;
									cnt_d      = vres.acc_next[CNT_W-1:0] + CNT_W'(COPY_BIAS);
								end
							end
						end
						default: begin
							// sticky error, phase holds
						end
					endcase
					load = !start_copy;
					// end of stream inside a token or at a token boundary
					if (last_q && !start_copy) begin
						case (phase_d) inside
							PH_BODY: end_stream = 1'b1;
							PH_HEAD, PH_LIT1, PH_OFF, PH_LEN: phase_d = PH_ERR_TRUNC;
							default: begin
							end
						endcase
					end
				end
			end
			S_READ: begin
				rd_en = 1'b1;
			end
			S_COPY: begin
				if (slot_free) begin
					load     = 1'b1;
					emit     = 1'b1;
					wr_data  = rd_data;
					res_last = (cnt_q == CNT_W'(1));
					cnt_d    = cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						phase_d    = PH_BODY;
						end_stream = last_q;
					end
				end
			end
			default: begin
			end
		endcase

		if (emit) begin
			wp_d = wp_q + AW'(1);
			if (wc_q < WC_W'(WINDOW_SIZE)) begin
				wc_d = wc_q + WC_W'(1);
			end
		end
		if (end_stream) begin
			wp_d    = '0;
			wc_d    = '0;
			phase_d = PH_HEAD;
		end
	end

	// result fields, errors carry no byte
	always_comb begin
		res_byte   = '0;
		res_has    = 1'b0;
		res_status = ST_OK;
		case (phase_d)
			PH_ERR_TRUNC: res_status = ST_TRUNC;
			PH_ERR_RANGE: res_status = ST_RANGE;
			PH_ERR_LONG:  res_status = ST_LONG;
			default: begin
				if (emit) begin
					res_byte = wr_data;
					res_has  = 1'b1;
				end
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_HEAD;
			wp_q        <= '0;
			wc_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			marker_q    <= '0;
			offset_q    <= '0;
			length_q    <= '0;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			wp_q     <= wp_d;
			wc_q     <= wc_d;
			cnt_q    <= cnt_d;
			marker_q <= marker_d;
			offset_q <= offset_d;
			length_q <= length_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// input capture and output register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_q <= in_byte;
			last_q <= in_last;
		end
		if (load) begin
			out_byte_q <= res_byte;
			out_has_q  <= res_has;
			out_last_q <= res_last;
			status_q   <= res_status;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign out_has_byte = out_has_q;
	assign out_last     = out_last_q;
	assign status       = status_q;

endmodule

// ===== hdl/lzmv_ram.sv =====
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
// no dependencies

module lzmv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/lzmv_varint_unit.sv =====
`timescale 1ns / 1ps
// shared varint step: shift-accumulate with saturation and limit compare
// depends on lzmv_pkg

module lzmv_varint_unit
	import lzmv_pkg::*;
(
	input  logic [ACC_W-1:0] acc,
	input  logic [7:0]       byte_in,
	input  logic [ACC_W-1:0] limit,
	output vres_t            res
);

	logic [ACC_W-1:0] nxt;

	always_comb begin
		if (acc > SAT_LIMIT) begin
			nxt = {ACC_W{1'b1}};
		end else begin
			nxt = {acc[ACC_W-8:0], 7'b0} | ACC_W'(byte_in & VAR_MASK);
		end
		res.acc_next = nxt;
		res.more     = byte_in[7];
		res.is_zero  = (nxt == '0);
		res.over     = (nxt > limit);
	end

endmodule

// ===== hdl/lzmv_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the lz decoder top level, with its bind
// depends on lzmv_pkg and lz_marker_varint_decoder_unit

module lzmv_checker
	import lzmv_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_has_byte,
	input logic       out_last,
	input logic [1:0] status
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status))
		else $error("stalled result changed");

	// one item in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

	// a result without a byte shows zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_has_byte |-> out_byte == 8'd0)
		else $error("empty result carries a byte value");

	// an error result is a single result with no byte
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> !out_has_byte && out_last)
		else $error("error result malformed");

endmodule

bind lz_marker_varint_decoder_unit lzmv_checker u_lzmv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.out_byte     (out_byte),
	.out_has_byte (out_has_byte),
	.out_last     (out_last),
	.status       (status)
);
